@@ hdl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hdl/sbda_pkg.sv @@
// shared constants and controller/datapath interface types
`timescale 1ns / 1ps

package sbda_pkg;

	localparam int VALUE_BITS = 32;
	localparam int MAX_DIGITS = 10;
	localparam int DIGIT_BITS = 4;
	localparam int BCD_BITS   = MAX_DIGITS * DIGIT_BITS;
	localparam int STEP_BITS  = $clog2(VALUE_BITS);
	localparam int CNT_BITS   = 4;
	localparam int IDX_BITS   = $clog2(MAX_DIGITS);
	localparam int SIZE_BITS  = 4;
	localparam int CHAR_BITS  = 8;
	localparam int RUN_BITS   = 5;

	localparam logic [SIZE_BITS-1:0] BUFFER_SIZE_RESET = 4'd10;
	localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic plan;
		logic emit;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic step_last;
		logic chars_left;
		logic slot_free;
	} dp_sts_t;

endpackage

@@ hdl/sbda_ctrl.sv @@
// controller state machine: accept, convert, plan, emit
`timescale 1ns / 1ps

module sbda_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sbda_pkg::dp_sts_t sts,
	output sbda_pkg::dp_cmd_t cmd
);
	import sbda_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_PLAN = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_CONV;
			ST_CONV: if (sts.step_last) state_d = ST_PLAN;
			ST_PLAN: state_d = ST_EMIT;
			ST_EMIT: if (!sts.chars_left) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// commands
	assign in_ready = (state_q == ST_IDLE);
	always_comb begin
		cmd      = '0;
		cmd.load = (state_q == ST_IDLE) && in_valid;
		cmd.step = (state_q == ST_CONV);
		cmd.plan = (state_q == ST_PLAN);
		cmd.emit = (state_q == ST_EMIT) && sts.chars_left && sts.slot_free;
	end

endmodule

@@ hdl/sbda_dpath.sv @@
// datapath: magnitude, shift-add-3 conversion, character sequencing, output register
`timescale 1ns / 1ps

module sbda_dpath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sbda_pkg::SIZE_BITS-1:0]   cfg_wdata,
	input  logic [sbda_pkg::VALUE_BITS-1:0]  in_value,
	input  sbda_pkg::dp_cmd_t                cmd,
	output sbda_pkg::dp_sts_t                sts,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [sbda_pkg::CHAR_BITS-1:0]   out_char,
	output logic                             out_last
);
	import sbda_pkg::*;

	logic [SIZE_BITS-1:0]  size_q;
	logic                  neg_q;
	logic [VALUE_BITS-1:0] bin_q;
	logic [BCD_BITS-1:0]   bcd_q;
	logic [STEP_BITS-1:0]  step_q;
	logic                  minus_q;
	logic [CNT_BITS-1:0]   dig_left_q;
	logic                  term_q;
	logic                  out_valid_q;
	logic [CHAR_BITS-1:0]  out_char_q;
	logic                  out_last_q;

	logic [BCD_BITS-1:0]   bcd_adj;
	logic [DIGIT_BITS-1:0] digits [MAX_DIGITS];
	logic [VALUE_BITS-1:0] mag;
	logic [CNT_BITS-1:0]   nd;
	logic                  has_minus;
	logic [CNT_BITS-1:0]   s1;
	logic [CNT_BITS-1:0]   kept;
	logic [RUN_BITS-1:0]   remaining;
	logic [IDX_BITS-1:0]   dig_idx;
	logic [CHAR_BITS-1:0]  next_char;

	// buffer size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= BUFFER_SIZE_RESET;
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
		end
	end

	// absolute value; the most negative input maps onto its exact magnitude
	assign mag = in_value[VALUE_BITS-1] ? (~in_value + VALUE_BITS'(1)) : in_value;

	// add 3 to every bcd digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			digits[i] = bcd_q[i*DIGIT_BITS +: DIGIT_BITS];
			bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = (digits[i] >= 4'd5) ?
				digits[i] + 4'd3 : digits[i];
		end
	end

	// conversion registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q  <= in_value[VALUE_BITS-1];
			bin_q  <= mag;
			bcd_q  <= '0;
			step_q <= '0;
		end else if (cmd.step) begin
			{bcd_q, bin_q} <= {bcd_adj[BCD_BITS-2:0], bin_q, 1'b0};
			step_q         <= step_q + STEP_BITS'(1);
		end
	end

	// significant digit count, at least one so zero prints as a single digit
	always_comb begin
		nd = CNT_BITS'(1);
		for (int i = 1; i < MAX_DIGITS; i++) begin
			if (digits[i] != '0) nd = CNT_BITS'(i + 1);
		end
	end

	// slot plan: sign first, then the low digits that fit, then the terminator
	assign has_minus = neg_q && (size_q != '0);
	assign s1        = size_q - {{(CNT_BITS-1){1'b0}}, has_minus};
	assign kept      = (nd < s1) ? nd : s1;

	// next character in the run
	assign remaining = {{(RUN_BITS-1){1'b0}}, minus_q} + {1'b0, dig_left_q}
		+ {{(RUN_BITS-1){1'b0}}, term_q};
	assign dig_idx   = IDX_BITS'(dig_left_q - CNT_BITS'(1));
	always_comb begin
		if (minus_q) begin
			next_char = CHAR_MINUS;
		end else if (dig_left_q != '0) begin
			next_char = CHAR_ZERO + {{(CHAR_BITS-DIGIT_BITS){1'b0}}, digits[dig_idx]};
		end else begin
			next_char = CHAR_NUL;
		end
	end

	// run bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minus_q    <= 1'b0;
			dig_left_q <= '0;
			term_q     <= 1'b0;
		end else if (cmd.plan) begin
			minus_q    <= has_minus;
			dig_left_q <= kept;
			term_q     <= (s1 != kept);
		end else if (cmd.emit) begin
			if (minus_q) begin
				minus_q <= 1'b0;
			end else if (dig_left_q != '0) begin
				dig_left_q <= dig_left_q - CNT_BITS'(1);
			end else begin
				term_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_char_q <= next_char;
			out_last_q <= (remaining == RUN_BITS'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

	// status
	assign sts.step_last  = (step_q == STEP_BITS'(VALUE_BITS - 1));
	assign sts.chars_left = (remaining != '0);
	assign sts.slot_free  = !out_valid_q || out_ready;

endmodule

@@ hdl/signed_binary_to_decimal_ascii.sv @@
// top level: signed binary to decimal ascii converter
//
// channel   direction  tdata                  tuser/tlast
// s_axis    in         [31:0] value           -
// m_axis    out        [7:0]  character       tlast = last_char
// cfg       in         [3:0]  buffer_size     write on cfg_we
//
// one item passes through an accept state, one shift-add-3 step per magnitude bit,
// a planning state, one character per cycle while m_axis is not stalled (0 to 12
// characters) and a closing step; the next item is taken only after the run has
// closed, once the last character has entered the output register
// arst_n clears the controller, the run counters and the output valid; size resets to 10
// a stalled m_axis holds the character and the run waits behind it
`timescale 1ns / 1ps
`include "assert_macros.svh"

module signed_binary_to_decimal_ascii (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sbda_pkg::SIZE_BITS-1:0]  cfg_wdata,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [sbda_pkg::VALUE_BITS-1:0] s_axis_tdata,  // [31:0] value
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [sbda_pkg::CHAR_BITS-1:0]  m_axis_tdata,  // [7:0] character
	output logic                            m_axis_tlast
);
	import sbda_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// controller
	sbda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	sbda_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_value  (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

	// no new item while characters of the previous run are still owed
	`ASSERT_IMPL(a_idle_no_run, s_axis_tready, !sts.chars_left)
	// a character is only loaded into a free output register
	`ASSERT_IMPL(a_emit_free, cmd.emit, sts.slot_free)
	// the last conversion step is followed by planning
	`ASSERT_NEXT(a_step_to_plan, cmd.step && sts.step_last, cmd.plan)

endmodule
